### hw/rtl/hsv2rgb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared types and constants of the HSV to RGB pixel converter.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  // Channel factors are fractions of one over 2^16, with one itself included.
  localparam int FACTOR_W = 17;
  localparam int PROD_W   = FACTOR_W + 8;

  localparam logic [FACTOR_W-1:0] FACTOR_ONE = FACTOR_W'(1) << 16;

  localparam logic [2:0] SECTOR_RED_YELLOW    = 3'd0;
  localparam logic [2:0] SECTOR_YELLOW_GREEN  = 3'd1;
  localparam logic [2:0] SECTOR_GREEN_CYAN    = 3'd2;
  localparam logic [2:0] SECTOR_CYAN_BLUE     = 3'd3;
  localparam logic [2:0] SECTOR_BLUE_MAGENTA  = 3'd4;

  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] brightness;
  } hsv_pixel_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_pixel_t;

  // Load enables of the two per-channel stages.
  typedef struct packed {
    logic en_mul;
    logic en_out;
  } chan_ctl_t;

endpackage : hsv2rgb_pkg
`default_nettype wire

### hw/rtl/hsv_to_rgb_converter_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_core
// Streaming 8-bit HSV to 8-bit RGB pixel converter.
// ----------------------------------------------------------------------------
// The converter takes one pixel beat per clock while in_ready is high and
// returns one RGB beat for each, in order. A beat passes sector_r, the
// factor registers, prod_r and level_r in that order; level_r drives
// out_data. It is a four-stage pipeline (hue sector split, channel factor
// select, value multiply, 255/256 scale) whose stages each hold a valid bit;
// a stage loads whenever it is empty or the stage after it moves, so stalls
// on the output side fill bubbles first and then hold in_ready low without
// losing a beat.
module hsv_to_rgb_converter_core (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       in_valid,
  output logic                      in_ready,
  input  wire hsv2rgb_pkg::hsv_pixel_t in_data,
  output logic                      out_valid,
  input  wire                       out_ready,
  output hsv2rgb_pkg::rgb_pixel_t   out_data
);
  import hsv2rgb_pkg::*;

  logic valid1_r, valid2_r, valid3_r, valid4_r;
  logic en1, en2, en3, en4;

  // Stage 1: sector and fraction of the scaled hue.
  logic [2:0]  sector_r;
  logic [7:0]  frac_r;
  logic [7:0]  sat1_r;
  logic [7:0]  val1_r;
  logic [10:0] hue6;

  // Stage 2: per-channel factors.
  logic [FACTOR_W-1:0] fac_red_r, fac_green_r, fac_blue_r;
  logic [FACTOR_W-1:0] fac_red_nxt, fac_green_nxt, fac_blue_nxt;
  logic [7:0]          val2_r;
  logic [15:0]         sat_frac;
  logic [FACTOR_W-1:0] sat_rest;
  logic [FACTOR_W-1:0] fac_p, fac_q, fac_t;
  logic [8:0]          sat_inv;
  logic [8:0]          frac_inv;

  chan_ctl_t chan_ctl;

  assign en4      = !valid4_r || out_ready;
  assign en3      = !valid3_r || en4;
  assign en2      = !valid2_r || en3;
  assign en1      = !valid1_r || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid1_r <= 1'b0;
      valid2_r <= 1'b0;
      valid3_r <= 1'b0;
      valid4_r <= 1'b0;
    end else begin
      if (en1) valid1_r <= in_valid;
      if (en2) valid2_r <= valid1_r;
      if (en3) valid3_r <= valid2_r;
      if (en4) valid4_r <= valid3_r;
    end
  end

  assign hue6 = 11'(in_data.hue) * 11'd6;

  always_ff @(posedge clk) begin
    if (en1) begin
      sector_r <= hue6[10:8];
      frac_r   <= hue6[7:0];
      sat1_r   <= in_data.saturation;
      val1_r   <= in_data.brightness;
    end
  end

  assign sat_inv  = 9'd256 - 9'(sat1_r);
  assign frac_inv = 9'd256 - 9'(frac_r);
  assign sat_frac = 16'(sat1_r) * 16'(frac_r);
  assign sat_rest = FACTOR_W'(sat1_r) * FACTOR_W'(frac_inv);
  assign fac_p    = {sat_inv, 8'b0};
  assign fac_q    = FACTOR_ONE - FACTOR_W'(sat_frac);
  assign fac_t    = FACTOR_ONE - sat_rest;

  always_comb begin
    case (sector_r)
      SECTOR_RED_YELLOW: begin
        fac_red_nxt = FACTOR_ONE; fac_green_nxt = fac_t; fac_blue_nxt = fac_p;
      end
      SECTOR_YELLOW_GREEN: begin
        fac_red_nxt = fac_q; fac_green_nxt = FACTOR_ONE; fac_blue_nxt = fac_p;
      end
      SECTOR_GREEN_CYAN: begin
        fac_red_nxt = fac_p; fac_green_nxt = FACTOR_ONE; fac_blue_nxt = fac_t;
      end
      SECTOR_CYAN_BLUE: begin
        fac_red_nxt = fac_p; fac_green_nxt = fac_q; fac_blue_nxt = FACTOR_ONE;
      end
      SECTOR_BLUE_MAGENTA: begin
        fac_red_nxt = fac_t; fac_green_nxt = fac_p; fac_blue_nxt = FACTOR_ONE;
      end
      default: begin
        fac_red_nxt = FACTOR_ONE; fac_green_nxt = fac_p; fac_blue_nxt = fac_q;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      fac_red_r   <= fac_red_nxt;
      fac_green_r <= fac_green_nxt;
      fac_blue_r  <= fac_blue_nxt;
      val2_r      <= val1_r;
    end
  end

  assign chan_ctl.en_mul = en3;
  assign chan_ctl.en_out = en4;

  hsv2rgb_chan u_chan_red (
    .clk    (clk),
    .ctl    (chan_ctl),
    .value  (val2_r),
    .factor (fac_red_r),
    .level  (out_data.red)
  );

  hsv2rgb_chan u_chan_green (
    .clk    (clk),
    .ctl    (chan_ctl),
    .value  (val2_r),
    .factor (fac_green_r),
    .level  (out_data.green)
  );

  hsv2rgb_chan u_chan_blue (
    .clk    (clk),
    .ctl    (chan_ctl),
    .value  (val2_r),
    .factor (fac_blue_r),
    .level  (out_data.blue)
  );

  assign out_valid = valid4_r;

endmodule : hsv_to_rgb_converter_core
`default_nettype wire

### hw/rtl/hsv2rgb_chan.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsv2rgb_chan
// One color channel: scales the value by the channel factor, then by 255/256
// with truncation, over two register stages.
// ----------------------------------------------------------------------------
module hsv2rgb_chan (
  input  wire                               clk,
  input  wire  hsv2rgb_pkg::chan_ctl_t      ctl,
  input  wire  [7:0]                        value,
  input  wire  [hsv2rgb_pkg::FACTOR_W-1:0]  factor,
  output logic [7:0]                        level
);
  import hsv2rgb_pkg::*;

  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] prod_nxt;
  logic [7:0]        level_r;
  logic [7:0]        level_nxt;
  logic [PROD_W+8:0] scaled;

  assign prod_nxt = PROD_W'(value) * PROD_W'(factor);

  // The product is a fraction over 2^24; times 255 is a shift and subtract.
  assign scaled    = {1'b0, prod_r, 8'b0} - (PROD_W+9)'(prod_r);
  assign level_nxt = scaled[31:24];

  always_ff @(posedge clk) begin
    if (ctl.en_mul) begin
      prod_r <= prod_nxt;
    end
    if (ctl.en_out) begin
      level_r <= level_nxt;
    end
  end

  assign level = level_r;

endmodule : hsv2rgb_chan
`default_nettype wire
